// ----- rtl/rte_pkg.sv -----
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types and constants for the render tile enumerator.
// ----------------------------------------------------------------------------
package rte_pkg;

	localparam int MAX_RESOLUTION = 16384;

	localparam int OP_W     = 2;
	localparam int COORD_W  = 15;
	localparam int QUERY_W  = 16;
	localparam int TILE_W   = 11;
	localparam int RADIUS_W = 7;
	localparam int INDEX_W  = 28;
	localparam int CFG_W    = 15;
	localparam int CFG_IDX_W = 3;

	// dividend width of the index divider, one quotient bit per step
	localparam int DIV_BITS = 15;
	localparam int DIV_CNT_W = $clog2(DIV_BITS);

	localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_RADIUS = 3'd4;

	localparam logic [COORD_W-1:0]  RST_IMAGE_WIDTH   = 15'd1920;
	localparam logic [COORD_W-1:0]  RST_IMAGE_HEIGHT  = 15'd1080;
	localparam logic [TILE_W-1:0]   RST_TILE_WIDTH    = 11'd32;
	localparam logic [TILE_W-1:0]   RST_TILE_HEIGHT   = 11'd32;
	localparam logic [RADIUS_W-1:0] RST_BORDER_RADIUS = 7'd0;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;      // input transfer this cycle
		logic div_load;  // load the dividers with a query
		logic div_step;  // one quotient bit
		logic mul_en;    // register row times tiles-per-row
		logic idx_out;   // write the query answer to the output register
	} rte_cmd_t;

endpackage

// ----- rtl/rte_div.sv -----
// ----------------------------------------------------------------------------
// rte_div
// Restoring divider, one quotient bit per step, unsigned operands.
// ----------------------------------------------------------------------------
module rte_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [rte_pkg::DIV_BITS-1:0] dividend,
	input  logic [rte_pkg::TILE_W-1:0]  divisor,
	output logic [rte_pkg::DIV_BITS-1:0] quotient
);
	import rte_pkg::*;

	logic [TILE_W-1:0]   rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [TILE_W:0]     trial;
	logic [TILE_W+1:0]   diff;

	assign trial = {rem_q, quo_q[DIV_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, divisor};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			if (!diff[TILE_W+1]) begin
				rem_q <= diff[TILE_W-1:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[TILE_W-1:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

// ----- rtl/rte_ctrl.sv -----
// ----------------------------------------------------------------------------
// rte_ctrl
// Sequencer for the tile enumerator: input acceptance and query steps.
// ----------------------------------------------------------------------------
module rte_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic [rte_pkg::OP_W-1:0]  op,
	input  logic                      out_free,
	output logic                      s_tready,
	output rte_pkg::rte_cmd_t         cmd
);
	import rte_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 take;

	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign take     = s_tvalid && s_tready;

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		cmd.take     = take;
		unique case (state_q)
			ST_IDLE: begin
				if (take && op == OP_QUERY) begin
					cmd.div_load = 1'b1;
					state_nxt    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_nxt  = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register before writing the answer
				if (out_free) begin
					cmd.idx_out = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/rte_dpath.sv -----
// ----------------------------------------------------------------------------
// rte_dpath
// Configuration, walk position, tile bounds, index dividers and output register.
// ----------------------------------------------------------------------------
module rte_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rte_pkg::rte_cmd_t              cmd,
	input  logic [rte_pkg::OP_W-1:0]       op,
	input  logic [rte_pkg::QUERY_W-1:0]    query_start_x,
	input  logic [rte_pkg::QUERY_W-1:0]    query_start_y,
	input  logic                           cfg_we,
	input  logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rte_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic                           out_free,
	output logic                           tile_valid,
	output logic [rte_pkg::COORD_W-1:0]    first_x,
	output logic [rte_pkg::COORD_W-1:0]    first_y,
	output logic [rte_pkg::COORD_W-1:0]    last_x,
	output logic [rte_pkg::COORD_W-1:0]    last_y,
	output logic [rte_pkg::INDEX_W-1:0]    linear_index
);
	import rte_pkg::*;

	localparam logic [COORD_W-1:0] MaxRes = COORD_W'(MAX_RESOLUTION);

	// configuration
	logic [COORD_W-1:0]  img_w_q, img_h_q;
	logic [TILE_W-1:0]   tile_w_q, tile_h_q;
	logic [RADIUS_W-1:0] radius_q;

	// walk state
	logic [13:0]        walk_x_q;
	logic [COORD_W-1:0] walk_y_q;
	logic               walk_done_q;

	// clamped sizes
	logic [COORD_W-1:0] w, h;
	logic [TILE_W-1:0]  tw, th;

	// pop arithmetic
	logic [16:0] sum_x, sum_y, ex, ey, ex_w, ey_w, ny_sel, rad17;
	logic        row_adv, walk_end, at_right, at_bottom;
	logic [COORD_W-1:0] fx, fy;

	// query
	logic [DIV_BITS-1:0] qx_clamp, qy_clamp, tpr_dvd;
	logic [15:0]         tpr_sum;
	logic [DIV_BITS-1:0] cx, cy, tpr;
	logic [INDEX_W-1:0]  product_q;
	logic [2*DIV_BITS-1:0] product;

	// output register
	logic               out_valid_q;
	logic               load_out;
	logic               tile_valid_nxt;
	logic [COORD_W-1:0] first_x_nxt, first_y_nxt, last_x_nxt, last_y_nxt;
	logic [INDEX_W-1:0] index_nxt;
	logic               tile_valid_q;
	logic [COORD_W-1:0] first_x_q, first_y_q, last_x_q, last_y_q;
	logic [INDEX_W-1:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q  <= RST_IMAGE_WIDTH;
			img_h_q  <= RST_IMAGE_HEIGHT;
			tile_w_q <= RST_TILE_WIDTH;
			tile_h_q <= RST_TILE_HEIGHT;
			radius_q <= RST_BORDER_RADIUS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   img_w_q  <= cfg_data;
				REG_IMAGE_HEIGHT:  img_h_q  <= cfg_data;
				REG_TILE_WIDTH:    tile_w_q <= cfg_data[TILE_W-1:0];
				REG_TILE_HEIGHT:   tile_h_q <= cfg_data[TILE_W-1:0];
				REG_BORDER_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// zero sizes count as one, images larger than the maximum are cut to it
	always_comb begin
		w  = (img_w_q == '0) ? COORD_W'(1) : ((img_w_q > MaxRes) ? MaxRes : img_w_q);
		h  = (img_h_q == '0) ? COORD_W'(1) : ((img_h_q > MaxRes) ? MaxRes : img_h_q);
		tw = (tile_w_q == '0) ? TILE_W'(1) : tile_w_q;
		th = (tile_h_q == '0) ? TILE_W'(1) : tile_h_q;
	end

	// tile bounds and next walk position
	always_comb begin
		rad17     = {10'd0, radius_q};
		sum_x     = {3'd0, walk_x_q} + {6'd0, tw};
		sum_y     = {2'd0, walk_y_q} + {6'd0, th};
		ex        = (sum_x > {2'd0, w}) ? {2'd0, w} : sum_x;
		ey        = (sum_y > {2'd0, h}) ? {2'd0, h} : sum_y;
		at_right  = (ex == {2'd0, w});
		at_bottom = (ey == {2'd0, h});
		ex_w      = at_right ? ex + rad17 : ex;
		ey_w      = at_bottom ? ey + rad17 : ey;
		fx        = (walk_x_q == '0) ? COORD_W'(0) - {8'd0, radius_q} : {1'b0, walk_x_q};
		fy        = (walk_y_q == '0) ? COORD_W'(0) - {8'd0, radius_q} : walk_y_q;
		row_adv   = (sum_x >= {2'd0, w});
		ny_sel    = row_adv ? sum_y : {2'd0, walk_y_q};
		walk_end  = (ny_sel >= {2'd0, h});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			walk_done_q <= 1'b0;
		end else if (cmd.take) begin
			if (op == OP_RESTART) begin
				walk_x_q    <= '0;
				walk_y_q    <= '0;
				walk_done_q <= 1'b0;
			end else if (op == OP_POP && !walk_done_q) begin
				walk_done_q <= walk_end;
				walk_x_q    <= (walk_end || row_adv) ? 14'd0 : sum_x[13:0];
				walk_y_q    <= walk_end ? COORD_W'(0) : ny_sel[COORD_W-1:0];
			end
		end
	end

	// negative start coordinates clamp to zero
	assign qx_clamp = query_start_x[QUERY_W-1] ? '0 : query_start_x[DIV_BITS-1:0];
	assign qy_clamp = query_start_y[QUERY_W-1] ? '0 : query_start_y[DIV_BITS-1:0];
	assign tpr_sum  = {1'b0, w} + {5'd0, tw} - 16'd1;
	assign tpr_dvd  = tpr_sum[DIV_BITS-1:0];

	rte_div u_div_x (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (qx_clamp),
		.divisor  (tw),
		.quotient (cx)
	);

	rte_div u_div_y (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (qy_clamp),
		.divisor  (th),
		.quotient (cy)
	);

	rte_div u_div_tpr (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (tpr_dvd),
		.divisor  (tw),
		.quotient (tpr)
	);

	assign product = cy * tpr;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			product_q <= product[INDEX_W-1:0];
		end
	end

	// result mux for the output register
	always_comb begin
		tile_valid_nxt = 1'b0;
		first_x_nxt    = '0;
		first_y_nxt    = '0;
		last_x_nxt     = '0;
		last_y_nxt     = '0;
		index_nxt      = '0;
		if (cmd.idx_out) begin
			index_nxt = product_q + {{(INDEX_W-DIV_BITS){1'b0}}, cx};
		end else if (op == OP_POP && !walk_done_q) begin
			tile_valid_nxt = 1'b1;
			first_x_nxt    = fx;
			first_y_nxt    = fy;
			last_x_nxt     = COORD_W'(ex_w - 17'd1);
			last_y_nxt     = COORD_W'(ey_w - 17'd1);
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign load_out = cmd.idx_out || (cmd.take && op != OP_QUERY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			tile_valid_q <= tile_valid_nxt;
			first_x_q    <= first_x_nxt;
			first_y_q    <= first_y_nxt;
			last_x_q     <= last_x_nxt;
			last_y_q     <= last_y_nxt;
			index_q      <= index_nxt;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign tile_valid   = tile_valid_q;
	assign first_x      = first_x_q;
	assign first_y      = first_y_q;
	assign last_x       = last_x_q;
	assign last_y       = last_y_q;
	assign linear_index = index_q;

endmodule

// ----- rtl/render_tile_enumerator.sv -----
// Restart, pop and idle ops: result in the output register in the cycle after the transfer,
// one item per cycle while the result side keeps up.
// Index query: 15 divider steps, one multiply and one add; the result write waits for room in
// the output register, and the next item is taken only after it is written (bit-serial divider).
// Reset (arst_n low, asynchronous): walk back at the first tile, registers to their defaults,
// output empty.
// ----------------------------------------------------------------------------
// render_tile_enumerator
// Raster walk over image tiles with border widening and tile index lookup.
// ----------------------------------------------------------------------------
module render_tile_enumerator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // query_start_x, query_start_y
	input  logic [1:0]                    s_tuser,  // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [87:0]                   m_tdata,  // first_x, first_y, last_x, last_y,
	                                                // linear_index
	output logic                          m_tuser,  // tile_valid
	input  logic                          cfg_we,
	input  logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rte_pkg::CFG_W-1:0]     cfg_data
);
	import rte_pkg::*;

	rte_cmd_t           cmd;
	logic               out_free;
	logic               tile_valid;
	logic [COORD_W-1:0] first_x, first_y, last_x, last_y;
	logic [INDEX_W-1:0] linear_index;

	rte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser),
		.out_free (out_free),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	rte_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (s_tuser),
		.query_start_x (s_tdata[15:0]),
		.query_start_y (s_tdata[31:16]),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.out_free      (out_free),
		.tile_valid    (tile_valid),
		.first_x       (first_x),
		.first_y       (first_y),
		.last_x        (last_x),
		.last_y        (last_y),
		.linear_index  (linear_index)
	);

	assign m_tdata = {linear_index, last_y, last_x, first_y, first_x};
	assign m_tuser = tile_valid;

endmodule
